// ----- rtl/spcdec_pkg.sv -----
// ----------------------------------------------------------------------------
// spcdec_pkg
// Types, codes and the opcode table for the SPC700 instruction decoder.
// ----------------------------------------------------------------------------
package spcdec_pkg;

    typedef struct packed {
        logic [7:0]  opcode;
        logic [7:0]  first_operand_byte;
        logic [7:0]  second_operand_byte;
        logic [15:0] instr_address;
    } dec_in_t;

    typedef struct packed {
        logic [6:0]  mnemonic;
        logic [4:0]  mode_code;
        logic [1:0]  instr_length;
        logic [2:0]  dest_reg;
        logic [2:0]  src_reg;
        logic [15:0] operand_address;
        logic [7:0]  second_dp_address;
        logic [7:0]  operand_value;
        logic [15:0] branch_target;
        logic        word_access;
        logic        code_target;
        logic        bit_inverted;
    } dec_out_t;

    // mnemonic classes, dense in order of first appearance in the opcode map
    typedef enum logic [6:0] {
        K_NOP, K_TCALL, K_SET0, K_BBS0, K_OR, K_OR1, K_ASL, K_PHP, K_TSET1, K_BRK,
        K_BPL, K_CLR0, K_BBC0, K_DECW, K_DEX, K_CPX, K_JMP, K_CLRP, K_SET1, K_BBS1,
        K_AND, K_ROL, K_PHA, K_CBNE, K_BRA, K_BMI, K_CLR1, K_BBC1, K_INCW, K_INX,
        K_CALL, K_SETP, K_SET2, K_BBS2, K_EOR, K_AND1, K_LSR, K_PHX, K_TCLR1, K_PCALL,
        K_BVC, K_CLR2, K_BBC2, K_CMPW, K_TAX, K_CPY, K_CLRC, K_SET3, K_BBS3, K_CMP,
        K_ROR, K_PHY, K_DBNZ, K_RET, K_BVS, K_CLR3, K_BBC3, K_ADDW, K_TXA, K_RETI,
        K_SETC, K_SET4, K_BBS4, K_ADC, K_EOR1, K_DEC, K_LDY, K_PLP, K_MOV, K_BCC,
        K_CLR4, K_BBC4, K_SUBW, K_TSX, K_DIV, K_XCN, K_EI, K_SET5, K_BBS5, K_SBC,
        K_MOV1, K_INC, K_PLA, K_STA, K_BCS, K_CLR5, K_BBC5, K_MOVW, K_TXS, K_DAS,
        K_LDA, K_DI, K_SET6, K_BBS6, K_STX, K_STY, K_LDX, K_PLX, K_MUL, K_BNE,
        K_CLR6, K_BBC6, K_DEY, K_TYA, K_DAA, K_CLRV, K_SET7, K_BBS7, K_NOT1, K_NOTC,
        K_PLY, K_SLEEP, K_BEQ, K_CLR7, K_BBC7, K_INY, K_TAY, K_STOP
    } mnem_t;

    // addressing modes
    localparam logic [4:0] AM_IMPL = 5'd0, AM_DP = 5'd1, AM_DPREL = 5'd2, AM_ABS = 5'd3,
        AM_IX = 5'd4, AM_DPXI = 5'd5, AM_IMM = 5'd6, AM_DPDP = 5'd7, AM_BIT = 5'd8,
        AM_REL = 5'd9, AM_DPX = 5'd10, AM_ABSX = 5'd11, AM_ABSY = 5'd12, AM_DPIY = 5'd13,
        AM_IMMDP = 5'd14, AM_IXIY = 5'd15, AM_ABSXI = 5'd16, AM_IXINC = 5'd17,
        AM_DPY = 5'd18, AM_DPXREL = 5'd19;

    // registers
    localparam logic [2:0] G_N = 3'd0, G_A = 3'd1, G_X = 3'd2, G_Y = 3'd3, G_YA = 3'd4,
        G_PSW = 3'd5, G_SP = 3'd6, G_C = 3'd7;

    localparam logic [7:0]  OP_OR1_INV  = 8'h2a;
    localparam logic [7:0]  OP_AND1_INV = 8'h6a;
    localparam logic [15:0] TCALL_BASE  = 16'hffde;
    localparam logic [15:0] PCALL_PAGE  = 16'hff00;
    localparam logic [15:0] BIT_ADDR_MASK = 16'h1fff;

    typedef struct packed {
        logic [6:0] mn;
        logic [4:0] am;
        logic [2:0] dr;
        logic [2:0] sr;
    } tab_entry_t;

    function automatic tab_entry_t te(input mnem_t m, input logic [4:0] a,
                                      input logic [2:0] d, input logic [2:0] s);
        tab_entry_t r;
        r.mn = m;
        r.am = a;
        r.dr = d;
        r.sr = s;
        return r;
    endfunction

    function automatic logic [1:0] mode_len(input logic [4:0] am);
        logic [1:0] l;
        case (am)
            AM_IMPL, AM_IX, AM_IXIY, AM_IXINC: l = 2'd1;
            AM_DPREL, AM_ABS, AM_DPDP, AM_BIT, AM_ABSX, AM_ABSY, AM_IMMDP, AM_ABSXI,
            AM_DPXREL: l = 2'd3;
            default: l = 2'd2;
        endcase
        return l;
    endfunction

    // opcode table; the low nibble column patterns repeat per row
    function automatic tab_entry_t dec_tab(input logic [7:0] op);
        tab_entry_t r;
        logic [3:0] hi;
        logic [3:0] lo;
        mnem_t alu;
        mnem_t k;
        hi = op[7:4];
        lo = op[3:0];
        r = te(K_NOP, AM_IMPL, G_N, G_N);
        // ALU family in columns 4..9, rows pair up: or,and,eor,cmp,adc,sbc
        case (hi[3:1])
            3'd0: alu = K_OR;
            3'd1: alu = K_AND;
            3'd2: alu = K_EOR;
            3'd3: alu = K_CMP;
            3'd4: alu = K_ADC;
            default: alu = K_SBC;
        endcase
        case (lo)
            4'h1: r = te(K_TCALL, AM_IMPL, G_N, G_N);
            4'h2: r = te(hi[0] ? K_CLR0 : K_SET0, AM_DP, G_N, G_N);
            default: ;
        endcase
        // single-bit ops and branches on bit: explicit codes
        if (lo == 4'h2 || lo == 4'h3) begin
            case (op)
                8'h02: k = K_SET0;  8'h12: k = K_CLR0;  8'h22: k = K_SET1;  8'h32: k = K_CLR1;
                8'h42: k = K_SET2;  8'h52: k = K_CLR2;  8'h62: k = K_SET3;  8'h72: k = K_CLR3;
                8'h82: k = K_SET4;  8'h92: k = K_CLR4;  8'ha2: k = K_SET5;  8'hb2: k = K_CLR5;
                8'hc2: k = K_SET6;  8'hd2: k = K_CLR6;  8'he2: k = K_SET7;  8'hf2: k = K_CLR7;
                8'h03: k = K_BBS0;  8'h13: k = K_BBC0;  8'h23: k = K_BBS1;  8'h33: k = K_BBC1;
                8'h43: k = K_BBS2;  8'h53: k = K_BBC2;  8'h63: k = K_BBS3;  8'h73: k = K_BBC3;
                8'h83: k = K_BBS4;  8'h93: k = K_BBC4;  8'ha3: k = K_BBS5;  8'hb3: k = K_BBC5;
                8'hc3: k = K_BBS6;  8'hd3: k = K_BBC6;  8'he3: k = K_BBS7;  8'hf3: k = K_BBC7;
                default: k = K_NOP;
            endcase
            r = te(k, lo[0] ? AM_DPREL : AM_DP, G_N, G_N);
        end
        if (hi < 4'hc && lo >= 4'h4 && lo <= 4'h9) begin
            if (!hi[0]) begin
                case (lo)
                    4'h4: r = te(alu, AM_DP, G_A, G_N);
                    4'h5: r = te(alu, AM_ABS, G_A, G_N);
                    4'h6: r = te(alu, AM_IX, G_A, G_N);
                    4'h7: r = te(alu, AM_DPXI, G_A, G_N);
                    4'h8: r = te(alu, AM_IMM, G_A, G_N);
                    default: r = te(alu, AM_DPDP, G_N, G_N);
                endcase
            end else begin
                case (lo)
                    4'h4: r = te(alu, AM_DPX, G_A, G_N);
                    4'h5: r = te(alu, AM_ABSX, G_A, G_N);
                    4'h6: r = te(alu, AM_ABSY, G_A, G_N);
                    4'h7: r = te(alu, AM_DPIY, G_A, G_N);
                    4'h8: r = te(alu, AM_IMMDP, G_N, G_N);
                    default: r = te(alu, AM_IXIY, G_N, G_N);
                endcase
            end
        end
        if (hi >= 4'he && lo >= 4'h4 && lo <= 4'h8) begin
            case (lo)
                4'h4: r = te(K_LDA, hi[0] ? AM_DPX : AM_DP, G_A, G_N);
                4'h5: r = te(K_LDA, hi[0] ? AM_ABSX : AM_ABS, G_A, G_N);
                4'h6: r = te(K_LDA, hi[0] ? AM_ABSY : AM_IX, G_A, G_N);
                4'h7: r = te(K_LDA, hi[0] ? AM_DPIY : AM_DPXI, G_A, G_N);
                default: r = hi[0] ? te(K_LDX, AM_DP, G_X, G_N) : te(K_LDA, AM_IMM, G_A, G_N);
            endcase
        end
        if ((hi == 4'hc || hi == 4'hd) && lo >= 4'h4 && lo <= 4'h7) begin
            case (lo)
                4'h4: r = te(K_STA, hi[0] ? AM_DPX : AM_DP, G_N, G_A);
                4'h5: r = te(K_STA, hi[0] ? AM_ABSX : AM_ABS, G_N, G_A);
                4'h6: r = te(K_STA, hi[0] ? AM_ABSY : AM_IX, G_N, G_A);
                default: r = te(K_STA, hi[0] ? AM_DPIY : AM_DPXI, G_N, G_A);
            endcase
        end
        case (op)
            8'h00: r = te(K_NOP, AM_IMPL, G_N, G_N);
            8'h0a: r = te(K_OR1, AM_BIT, G_C, G_N);
            8'h0b: r = te(K_ASL, AM_DP, G_N, G_N);
            8'h0c: r = te(K_ASL, AM_ABS, G_N, G_N);
            8'h0d: r = te(K_PHP, AM_IMPL, G_PSW, G_N);
            8'h0e: r = te(K_TSET1, AM_ABS, G_N, G_N);
            8'h0f: r = te(K_BRK, AM_IMPL, G_N, G_N);
            8'h10: r = te(K_BPL, AM_REL, G_N, G_N);
            8'h1a: r = te(K_DECW, AM_DP, G_N, G_N);
            8'h1b: r = te(K_ASL, AM_DPX, G_N, G_N);
            8'h1c: r = te(K_ASL, AM_IMPL, G_A, G_N);
            8'h1d: r = te(K_DEX, AM_IMPL, G_X, G_N);
            8'h1e: r = te(K_CPX, AM_ABS, G_X, G_N);
            8'h1f: r = te(K_JMP, AM_ABSXI, G_N, G_N);
            8'h20: r = te(K_CLRP, AM_IMPL, G_N, G_N);
            8'h2a: r = te(K_OR1, AM_BIT, G_C, G_N);
            8'h2b: r = te(K_ROL, AM_DP, G_N, G_N);
            8'h2c: r = te(K_ROL, AM_ABS, G_N, G_N);
            8'h2d: r = te(K_PHA, AM_IMPL, G_A, G_N);
            8'h2e: r = te(K_CBNE, AM_DPREL, G_N, G_N);
            8'h2f: r = te(K_BRA, AM_REL, G_N, G_N);
            8'h30: r = te(K_BMI, AM_REL, G_N, G_N);
            8'h3a: r = te(K_INCW, AM_DP, G_N, G_N);
            8'h3b: r = te(K_ROL, AM_DPX, G_N, G_N);
            8'h3c: r = te(K_ROL, AM_IMPL, G_A, G_N);
            8'h3d: r = te(K_INX, AM_IMPL, G_X, G_N);
            8'h3e: r = te(K_CPX, AM_DP, G_X, G_N);
            8'h3f: r = te(K_CALL, AM_ABS, G_N, G_N);
            8'h40: r = te(K_SETP, AM_IMPL, G_N, G_N);
            8'h4a: r = te(K_AND1, AM_BIT, G_C, G_N);
            8'h4b: r = te(K_LSR, AM_DP, G_N, G_N);
            8'h4c: r = te(K_LSR, AM_ABS, G_N, G_N);
            8'h4d: r = te(K_PHX, AM_IMPL, G_X, G_N);
            8'h4e: r = te(K_TCLR1, AM_ABS, G_N, G_N);
            8'h4f: r = te(K_PCALL, AM_DP, G_N, G_N);
            8'h50: r = te(K_BVC, AM_REL, G_N, G_N);
            8'h5a: r = te(K_CMPW, AM_DP, G_YA, G_N);
            8'h5b: r = te(K_LSR, AM_DPX, G_N, G_N);
            8'h5c: r = te(K_LSR, AM_IMPL, G_A, G_N);
            8'h5d: r = te(K_TAX, AM_IMPL, G_X, G_A);
            8'h5e: r = te(K_CPY, AM_ABS, G_Y, G_N);
            8'h5f: r = te(K_JMP, AM_ABS, G_N, G_N);
            8'h60: r = te(K_CLRC, AM_IMPL, G_N, G_N);
            8'h6a: r = te(K_AND1, AM_BIT, G_C, G_N);
            8'h6b: r = te(K_ROR, AM_DP, G_N, G_N);
            8'h6c: r = te(K_ROR, AM_ABS, G_N, G_N);
            8'h6d: r = te(K_PHY, AM_IMPL, G_Y, G_N);
            8'h6e: r = te(K_DBNZ, AM_DPREL, G_N, G_N);
            8'h6f: r = te(K_RET, AM_IMPL, G_N, G_N);
            8'h70: r = te(K_BVS, AM_REL, G_N, G_N);
            8'h7a: r = te(K_ADDW, AM_DP, G_YA, G_N);
            8'h7b: r = te(K_ROR, AM_DPX, G_N, G_N);
            8'h7c: r = te(K_ROR, AM_IMPL, G_A, G_N);
            8'h7d: r = te(K_TXA, AM_IMPL, G_A, G_X);
            8'h7e: r = te(K_CPY, AM_DP, G_Y, G_N);
            8'h7f: r = te(K_RETI, AM_IMPL, G_N, G_N);
            8'h80: r = te(K_SETC, AM_IMPL, G_N, G_N);
            8'h8a: r = te(K_EOR1, AM_BIT, G_C, G_N);
            8'h8b: r = te(K_DEC, AM_DP, G_N, G_N);
            8'h8c: r = te(K_DEC, AM_ABS, G_N, G_N);
            8'h8d: r = te(K_LDY, AM_IMM, G_Y, G_N);
            8'h8e: r = te(K_PLP, AM_IMPL, G_PSW, G_N);
            8'h8f: r = te(K_MOV, AM_IMMDP, G_N, G_N);
            8'h90: r = te(K_BCC, AM_REL, G_N, G_N);
            8'h9a: r = te(K_SUBW, AM_DP, G_YA, G_N);
            8'h9b: r = te(K_DEC, AM_DPX, G_N, G_N);
            8'h9c: r = te(K_DEC, AM_IMPL, G_A, G_N);
            8'h9d: r = te(K_TSX, AM_IMPL, G_X, G_SP);
            8'h9e: r = te(K_DIV, AM_IMPL, G_YA, G_X);
            8'h9f: r = te(K_XCN, AM_IMPL, G_N, G_N);
            8'ha0: r = te(K_EI, AM_IMPL, G_N, G_N);
            8'haa: r = te(K_MOV1, AM_BIT, G_C, G_N);
            8'hab: r = te(K_INC, AM_DP, G_N, G_N);
            8'hac: r = te(K_INC, AM_ABS, G_N, G_N);
            8'had: r = te(K_CPY, AM_IMM, G_Y, G_N);
            8'hae: r = te(K_PLA, AM_IMPL, G_A, G_N);
            8'haf: r = te(K_STA, AM_IXINC, G_N, G_A);
            8'hb0: r = te(K_BCS, AM_REL, G_N, G_N);
            8'hba: r = te(K_MOVW, AM_DP, G_YA, G_N);
            8'hbb: r = te(K_INC, AM_DPX, G_N, G_N);
            8'hbc: r = te(K_INC, AM_IMPL, G_A, G_N);
            8'hbd: r = te(K_TXS, AM_IMPL, G_SP, G_X);
            8'hbe: r = te(K_DAS, AM_IMPL, G_A, G_N);
            8'hbf: r = te(K_LDA, AM_IXINC, G_A, G_N);
            8'hc0: r = te(K_DI, AM_IMPL, G_N, G_N);
            8'hc8: r = te(K_CPX, AM_IMM, G_X, G_N);
            8'hc9: r = te(K_STX, AM_ABS, G_N, G_X);
            8'hca: r = te(K_MOV1, AM_BIT, G_N, G_C);
            8'hcb: r = te(K_STY, AM_DP, G_N, G_Y);
            8'hcc: r = te(K_STY, AM_ABS, G_N, G_Y);
            8'hcd: r = te(K_LDX, AM_IMM, G_X, G_N);
            8'hce: r = te(K_PLX, AM_IMPL, G_X, G_N);
            8'hcf: r = te(K_MUL, AM_IMPL, G_YA, G_N);
            8'hd0: r = te(K_BNE, AM_REL, G_N, G_N);
            8'hd8: r = te(K_STX, AM_DP, G_N, G_X);
            8'hd9: r = te(K_STX, AM_DPY, G_N, G_X);
            8'hda: r = te(K_MOVW, AM_DP, G_N, G_YA);
            8'hdb: r = te(K_STY, AM_DPX, G_N, G_Y);
            8'hdc: r = te(K_DEY, AM_IMPL, G_Y, G_N);
            8'hdd: r = te(K_TYA, AM_IMPL, G_A, G_Y);
            8'hde: r = te(K_CBNE, AM_DPXREL, G_N, G_N);
            8'hdf: r = te(K_DAA, AM_IMPL, G_A, G_N);
            8'he0: r = te(K_CLRV, AM_IMPL, G_N, G_N);
            8'he9: r = te(K_LDX, AM_ABS, G_X, G_N);
            8'hea: r = te(K_NOT1, AM_BIT, G_N, G_N);
            8'heb: r = te(K_LDY, AM_DP, G_Y, G_N);
            8'hec: r = te(K_LDY, AM_ABS, G_Y, G_N);
            8'hed: r = te(K_NOTC, AM_IMPL, G_N, G_N);
            8'hee: r = te(K_PLY, AM_IMPL, G_Y, G_N);
            8'hef: r = te(K_SLEEP, AM_IMPL, G_N, G_N);
            8'hf0: r = te(K_BEQ, AM_REL, G_N, G_N);
            8'hf9: r = te(K_LDX, AM_DPY, G_X, G_N);
            8'hfa: r = te(K_MOV, AM_DPDP, G_N, G_N);
            8'hfb: r = te(K_LDY, AM_DPX, G_Y, G_N);
            8'hfc: r = te(K_INY, AM_IMPL, G_Y, G_N);
            8'hfd: r = te(K_TAY, AM_IMPL, G_Y, G_A);
            8'hfe: r = te(K_DBNZ, AM_REL, G_Y, G_N);
            8'hff: r = te(K_STOP, AM_IMPL, G_N, G_N);
            default: ;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/spcdec_operands.sv -----
// ----------------------------------------------------------------------------
// spcdec_operands
// Registered operand extraction from a decoded table entry.
// ----------------------------------------------------------------------------
module spcdec_operands
    import spcdec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  dec_in_t    in_item,
    input  tab_entry_t in_entry,
    output logic       out_valid,
    output dec_out_t   out_item,
    output logic [7:0] out_offset,
    output logic [15:0] out_base
);

    logic       valid_reg;
    dec_out_t   item_reg, item_next;
    logic [7:0] off_reg, off_next;
    logic [15:0] base_reg;

    always_comb
    begin
        logic [15:0] word;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic [6:0]  mn;
        word = {in_item.second_operand_byte, in_item.first_operand_byte};
        b1   = in_item.first_operand_byte;
        b2   = in_item.second_operand_byte;
        mn   = in_entry.mn;
        item_next = '0;
        item_next.mnemonic     = mn;
        item_next.mode_code    = in_entry.am;
        item_next.instr_length = mode_len(in_entry.am);
        item_next.dest_reg     = in_entry.dr;
        item_next.src_reg      = in_entry.sr;
        off_next = 8'd0;
        case (in_entry.am)
            AM_IMPL:
            begin
                if (mn == K_TCALL) begin
                    item_next.operand_value   = {4'd0, in_item.opcode[7:4]};
                    item_next.operand_address = TCALL_BASE - {11'd0, in_item.opcode[7:4], 1'b0};
                end
            end
            AM_DP:
            begin
                if (mn == K_PCALL) begin
                    item_next.operand_value   = b1;
                    item_next.operand_address = PCALL_PAGE | {8'd0, b1};
                end else begin
                    item_next.operand_address = {8'd0, b1};
                    item_next.word_access = (mn == K_DECW) || (mn == K_INCW) ||
                        (mn == K_CMPW) || (mn == K_ADDW) || (mn == K_SUBW) || (mn == K_MOVW);
                end
            end
            AM_DPX, AM_DPY, AM_DPXI, AM_DPIY: item_next.operand_address = {8'd0, b1};
            AM_IMM: item_next.operand_value = b1;
            AM_IMMDP:
            begin
                item_next.operand_value   = b1;
                item_next.operand_address = {8'd0, b2};
            end
            AM_ABS:
            begin
                item_next.operand_address = word;
                item_next.code_target = (mn == K_CALL) || (mn == K_JMP);
            end
            AM_ABSX, AM_ABSY: item_next.operand_address = word;
            AM_ABSXI:
            begin
                item_next.operand_address = word;
                item_next.word_access = (mn == K_JMP);
            end
            AM_BIT:
            begin
                item_next.operand_address = word & BIT_ADDR_MASK;
                item_next.operand_value   = {5'd0, word[15:13]};
                item_next.bit_inverted = (in_item.opcode == OP_OR1_INV) ||
                    (in_item.opcode == OP_AND1_INV);
            end
            AM_DPDP:
            begin
                item_next.operand_address   = {8'd0, b2};
                item_next.second_dp_address = b1;
            end
            AM_DPREL, AM_DPXREL:
            begin
                item_next.operand_address = {8'd0, b1};
                off_next = b2;
            end
            AM_REL: off_next = b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        off_reg  <= off_next;
        base_reg <= in_item.instr_address + {14'd0, mode_len(in_entry.am)};
    end

    assign out_valid  = valid_reg;
    assign out_item   = item_reg;
    assign out_offset = off_reg;
    assign out_base   = base_reg;

endmodule

// ----- rtl/spc700_instruction_decoder.sv -----
// ----------------------------------------------------------------------------
// spc700_instruction_decoder
// Pipelined SPC700 opcode decoder with operand and branch target extraction.
// ----------------------------------------------------------------------------
// Takes one instruction per clock: busy is never raised, so a start pulse in
// any cycle is a transfer. The result appears on result with done high as it
// leaves stage 3, for one cycle only; the receiver must take it then. Stage 1
// registers the table entry, stage 2 the operand fields and address plus
// length, stage 3 the branch target (one 16-bit add of the signed offset).
// ----------------------------------------------------------------------------
module spc700_instruction_decoder
    import spcdec_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  dec_in_t  operands,
    output logic     done,
    output dec_out_t result
);

    // stage 1: table lookup
    logic       s1_valid_reg;
    dec_in_t    s1_item_reg;
    tab_entry_t s1_entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= start && !busy;
    end

    always_ff @(posedge clk)
    begin
        s1_item_reg  <= operands;
        s1_entry_reg <= dec_tab(operands.opcode);
    end

    // stage 2: operand fields
    logic        s2_valid;
    dec_out_t    s2_item;
    logic [7:0]  s2_offset;
    logic [15:0] s2_base;

    spcdec_operands u_operands (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s1_valid_reg),
        .in_item    (s1_item_reg),
        .in_entry   (s1_entry_reg),
        .out_valid  (s2_valid),
        .out_item   (s2_item),
        .out_offset (s2_offset),
        .out_base   (s2_base)
    );

    // stage 3: branch target, zero for non-relative modes
    logic     s3_valid_reg;
    dec_out_t s3_item_reg, s3_item_next;
    logic     is_rel;

    assign is_rel = (s2_item.mode_code == AM_REL) || (s2_item.mode_code == AM_DPREL) ||
                    (s2_item.mode_code == AM_DPXREL);

    always_comb
    begin
        s3_item_next = s2_item;
        s3_item_next.branch_target = is_rel ?
            s2_base + {{8{s2_offset[7]}}, s2_offset} : 16'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= s2_valid;
    end

    always_ff @(posedge clk)
    begin
        s3_item_reg <= s3_item_next;
    end

    assign busy   = 1'b0;
    assign done   = s3_valid_reg;
    assign result = s3_item_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##3 done) else $error("transfer lost in pipeline");
    a_len: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.instr_length != 2'd0)) else $error("bad length");
    a_tgt: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.mode_code == AM_IMPL) |-> (result.branch_target == 16'd0))
        else $error("target on implied mode");

endmodule
